// ===== design/cat_frequency_field_codec_unit_macros.svh =====
// Assertion macros shared by the checker of the frequency field codec.
`ifndef CAT_FREQUENCY_FIELD_CODEC_UNIT_MACROS_SVH
`define CAT_FREQUENCY_FIELD_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define CFU_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) trig |=> cons) else $error(msg);

`endif

// ===== design/cfu_pkg.sv =====
// Shared types and constants of the frequency field codec.
package cfu_pkg;

    localparam int DEF_MAX_FIELD_BYTES = 16;
    localparam int FREQ_W = 54;
    localparam int RES_W = 17;
    localparam int ACC_W = 64;
    localparam int DIV_W = ACC_W + RES_W;
    localparam int NUM_DIGITS = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam logic [FREQ_W-1:0] FREQ_CAP = 54'd9999999999999999;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [RES_W-1:0] CENTI_BASE = 17'd100;

    typedef enum logic [1:0] {
        FMT_BCD = 2'd0,
        FMT_BIN = 2'd1,
        FMT_DEC = 2'd2
    } t_fmt;

    typedef enum logic [2:0] {
        REG_FORMAT      = 3'd0,
        REG_LEAST_FIRST = 3'd1,
        REG_LENGTH      = 3'd2,
        REG_RES         = 3'd3,
        REG_FMIN        = 3'd4,
        REG_FMAX        = 3'd5
    } t_reg_idx;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DEC,
        B_MUL,
        B_C100,
        B_DIVGO,
        B_DIV,
        B_FOUT,
        B_DD,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic [1:0]        field_format;
        logic              least_first;
        logic [4:0]        field_length;
        logic [RES_W-1:0]  resolution_centi;
        logic [FREQ_W-1:0] freq_min;
        logic [FREQ_W-1:0] freq_max;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [FREQ_W-1:0] freq;
        logic [7:0]        field_byte;
        logic              field_end;
    } t_cmd;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        field_byte_out;
        logic              run_end;
        logic [FREQ_W-1:0] freq_out;
        logic              freq_valid;
    } t_res;

endpackage

// ===== design/cat_frequency_field_codec_unit.sv =====
// Top level of the transceiver frequency field codec.
//
// This block turns a frequency in hertz into the bytes of a transceiver command field and
// turns received field bytes back into a frequency. An encode transfer (tuser low) carries a
// frequency; the block scales it to field units, freq * 100 / resolution_centi, and sends the
// field as one output transfer per byte, tlast marking the final byte. A decode transfer
// (tuser high) carries one field byte, tlast marking the final byte of the field; only the
// final byte produces an output transfer, holding the scaled, saturated frequency and its
// range check. Fields are packed BCD, raw binary or ASCII decimal, most significant byte
// first unless least_first is set. Input transfers are queued two deep in front of the
// worker, and a result register lets the worker go on while a result waits. An encode passes
// through the bit-serial divider and then the binary to decimal shift stage before its bytes
// are sent. A decode byte that is not final only updates the accumulator; the final byte also
// runs a 17-step shift-add multiply and a 9-step division by one hundred that retires nine
// quotient bits per cycle.
// Configuration is written through the APB port at byte address 8 * index and should only be
// changed while no transfer is in flight.
module cat_frequency_field_codec_unit import cfu_pkg::*; #(
    parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // freq_in [53:0], field_byte_in [61:54], zeros above
    input  logic        s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // field_end_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // field_byte_out [7:0], freq_out [61:8],
                                        // freq_valid [62], zero above
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // run_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Configuration registers, reset to their documented defaults.
    t_cfg r_cfg;
    logic cfg_wr;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_ready;
    logic res_valid;
    t_res res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_format     <= FMT_BCD;
            r_cfg.least_first      <= 1'b0;
            r_cfg.field_length     <= 5'd8;
            r_cfg.resolution_centi <= CENTI_BASE;
            r_cfg.freq_min         <= '0;
            r_cfg.freq_max         <= FREQ_CAP;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[5:3]))
                REG_FORMAT:      r_cfg.field_format     <= pwdata[1:0];
                REG_LEAST_FIRST: r_cfg.least_first      <= pwdata[0];
                REG_LENGTH:      r_cfg.field_length     <= pwdata[4:0];
                REG_RES:         r_cfg.resolution_centi <= pwdata[RES_W-1:0];
                REG_FMIN:        r_cfg.freq_min         <= pwdata[FREQ_W-1:0];
                REG_FMAX:        r_cfg.freq_max         <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads return the stored value, zero extended.
    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_FORMAT:      prdata = 64'(r_cfg.field_format);
            REG_LEAST_FIRST: prdata = 64'(r_cfg.least_first);
            REG_LENGTH:      prdata = 64'(r_cfg.field_length);
            REG_RES:         prdata = 64'(r_cfg.resolution_centi);
            REG_FMIN:        prdata = 64'(r_cfg.freq_min);
            REG_FMAX:        prdata = 64'(r_cfg.freq_max);
            default:         prdata = 64'd0;
        endcase
    end

    // The front end accepts and classifies transfers into a short queue.
    cfu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    // The back end works one queued item at a time and owns the result register.
    cfu_back #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {1'b0, res.freq_valid, res.freq_out, res.field_byte_out};
    assign m_axis_tuser  = res.result_kind;
    assign m_axis_tlast  = res.run_end;

endmodule

// ===== design/cfu_front.sv =====
// Front end: accepts stream transfers, classifies them and queues them.
module cfu_front import cfu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data,
    input  logic        i_user,
    input  logic        i_last,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ready
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_fill;
    t_cmd              cmd_in;
    logic              push;
    logic              pop;

    always_comb begin
        cmd_in.op         = i_user ? OP_DEC : OP_ENC;
        cmd_in.freq       = i_data[FREQ_W-1:0];
        cmd_in.field_byte = i_data[FREQ_W+7:FREQ_W];
        cmd_in.field_end  = i_last;
    end

    assign o_ready     = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_mem[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== design/cfu_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module cfu_div import cfu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [RES_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RES_W-1:0] r_rem;
    logic [RES_W-1:0] r_dvsr;
    logic [DIV_W-1:0] r_q;
    logic [RES_W:0]   rem_sh;
    logic             ge;
    logic [RES_W:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_q[DIV_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvsr});
        diff   = rem_sh - {1'b0, r_dvsr};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? diff[RES_W-1:0] : rem_sh[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/cfu_back.sv =====
// Back end: decode accumulation, scaling, digit conversion and result output.
module cfu_back import cfu_pkg::*; #(
    parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_ready,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);
    // The decoded product is divided by one hundred nine bits at a time; a partial
    // dividend below 51200 is divided exactly by a reciprocal scaled by 2^23.
    localparam int CHUNK_W = 9;
    localparam int C100_STEPS = DIV_W / CHUNK_W;
    localparam logic [16:0] RECIP_100 = 17'd83887;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] mul_base(input logic [ACC_W-1:0] x,
                                                  input logic [1:0] fmt);
        logic [ACC_W+7:0] p;
        case (fmt)
            FMT_BCD: p = ((ACC_W+8)'(x) << 6) + ((ACC_W+8)'(x) << 5) + ((ACC_W+8)'(x) << 2);
            FMT_BIN: p = (ACC_W+8)'(x) << 8;
            default: p = ((ACC_W+8)'(x) << 3) + ((ACC_W+8)'(x) << 1);
        endcase
        return (p[ACC_W+7:ACC_W] != '0) ? '1 : p[ACC_W-1:0];
    endfunction

    function automatic logic [3:0] bcd_digit(input logic [4*NUM_DIGITS-1:0] b,
                                             input int unsigned j);
        return (j < NUM_DIGITS) ? b[4*j +: 4] : 4'd0;
    endfunction

    t_bstate              r_state;
    t_bstate              n_state;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [ACC_W-1:0]     r_pw, n_pw;
    logic [4:0]           r_seen, n_seen;
    logic [7:0]           r_byte, n_byte;
    logic                 r_last, n_last;
    logic [DIV_W-1:0]     r_mcand, n_mcand;
    logic [RES_W-1:0]     r_mplier, n_mplier;
    logic [DIV_W-1:0]     r_prod, n_prod;
    logic [RES_W-1:0]     r_dvsr, n_dvsr;
    logic [6:0]           r_cnt, n_cnt;
    logic [6:0]           r_rem100, n_rem100;
    logic [ACC_W-1:0]     r_bin, n_bin;
    logic [4*NUM_DIGITS-1:0] r_bcd, n_bcd;
    logic [ACC_W-1:0]     r_v, n_v;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_ov, n_ov;
    t_res                 r_out, n_out;

    logic [6:0]           raw_n;
    logic [CNT_W-1:0]     nbytes;
    logic [RES_W-1:0]     res_nz;
    logic                 out_free;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;
    logic [7:0]           dval;
    logic [ACC_W+7:0]     pv;
    logic [ACC_W-1:0]     pv_sat;
    logic [ACC_W-1:0]     acc_new;
    logic [ACC_W-1:0]     pw_new;
    logic                 dec_ok;
    logic [4*NUM_DIGITS-1:0] bcd_adj;
    logic [CNT_W-1:0]     k;
    logic [7:0]           enc_byte;
    logic [FREQ_W-1:0]    fsat;
    logic [15:0]          c_num;
    logic [31:0]          c_prodm;
    logic [CHUNK_W-1:0]   c_q;
    logic [15:0]          c_rm;
    logic [6:0]           c_r;

    cfu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dvsr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Field size in bytes for the current format and length.
    always_comb begin
        case (i_cfg.field_format)
            FMT_BCD: raw_n = (7'(i_cfg.field_length) + 7'd1) >> 1;
            FMT_BIN: raw_n = 7'(i_cfg.field_length);
            FMT_DEC: raw_n = 7'(i_cfg.field_length);
            default: raw_n = 7'd0;
        endcase
        nbytes = (raw_n > 7'(MAX_FIELD_BYTES)) ? CNT_W'(MAX_FIELD_BYTES) : CNT_W'(raw_n);
        res_nz = (i_cfg.resolution_centi == '0) ? RES_W'(1) : i_cfg.resolution_centi;
    end

    assign out_free    = !r_ov || i_res_ready;
    assign o_cmd_ready = (r_state == B_IDLE);
    assign div_start   = (r_state == B_DIVGO);

    // Per-byte decode arithmetic.
    always_comb begin
        case (i_cfg.field_format)
            FMT_BCD: dval = (8'(r_byte[7:4]) << 3) + (8'(r_byte[7:4]) << 1) + 8'(r_byte[3:0]);
            FMT_BIN: dval = r_byte;
            default: dval = r_byte - ASCII_ZERO;
        endcase
        pv = ((ACC_W+8)'(40'(r_pw[63:32]) * 40'(dval)) << 32)
           + (ACC_W+8)'(40'(r_pw[31:0]) * 40'(dval));
        pv_sat = (pv[ACC_W+7:ACC_W] != '0) ? '1 : pv[ACC_W-1:0];
        dec_ok = (i_cfg.field_format != 2'd3) && (7'(r_seen) < 7'(nbytes));
        acc_new = r_acc;
        pw_new  = r_pw;
        if (dec_ok) begin
            if (i_cfg.least_first) begin
                acc_new = sat_add(r_acc, pv_sat);
                pw_new  = mul_base(r_pw, i_cfg.field_format);
            end else begin
                acc_new = sat_add(mul_base(r_acc, i_cfg.field_format), ACC_W'(dval));
            end
        end
    end

    // One radix-512 step of the division by one hundred.
    always_comb begin
        c_num   = {r_rem100, r_prod[DIV_W-1 -: CHUNK_W]};
        c_prodm = 32'(c_num) * 32'(RECIP_100);
        c_q     = c_prodm[31:23];
        c_rm    = c_num - 16'(c_q) * 16'd100;
        c_r     = c_rm[6:0];
    end

    // Encode byte selection and double-dabble adjust.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
        k = i_cfg.least_first ? r_idx : nbytes - CNT_W'(1) - r_idx;
        case (i_cfg.field_format)
            FMT_BCD: enc_byte = {bcd_digit(r_bcd, 2*int'(k) + 1), bcd_digit(r_bcd, 2*int'(k))};
            FMT_BIN: enc_byte = (int'(k) < 8) ? r_v[8*int'(k) +: 8] : 8'd0;
            FMT_DEC: enc_byte = ASCII_ZERO + {4'd0, bcd_digit(r_bcd, int'(k))};
            default: enc_byte = 8'd0;
        endcase
        fsat = (r_prod > DIV_W'(FREQ_CAP)) ? FREQ_CAP : r_prod[FREQ_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_ENC) begin
                        n_state = (nbytes == '0) ? B_IDLE : B_DIVGO;
                    end else begin
                        n_state = B_DEC;
                    end
                end
            end
            B_DEC:   n_state = r_last ? B_MUL : B_IDLE;
            B_MUL: begin
                if (r_cnt == 7'(RES_W - 1)) n_state = B_C100;
            end
            B_C100: begin
                if (r_cnt == 7'(C100_STEPS - 1)) n_state = B_FOUT;
            end
            B_DIVGO: n_state = B_DIV;
            B_DIV: begin
                if (div_done) n_state = B_DD;
            end
            B_FOUT: begin
                if (out_free) n_state = B_IDLE;
            end
            B_DD: begin
                if (r_cnt == 7'(ACC_W - 1)) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free && r_idx == nbytes - CNT_W'(1)) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb begin
        n_acc    = r_acc;
        n_pw     = r_pw;
        n_seen   = r_seen;
        n_byte   = r_byte;
        n_last   = r_last;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_prod   = r_prod;
        n_dvsr   = r_dvsr;
        n_cnt    = r_cnt;
        n_rem100 = r_rem100;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_v      = r_v;
        n_idx    = r_idx;
        n_out    = r_out;
        n_ov     = r_ov && !i_res_ready;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_byte   = i_cmd.field_byte;
                    n_last   = i_cmd.field_end;
                    n_prod   = (DIV_W'(i_cmd.freq) << 6) + (DIV_W'(i_cmd.freq) << 5)
                             + (DIV_W'(i_cmd.freq) << 2);
                    n_dvsr   = res_nz;
                    n_idx    = '0;
                end
            end
            B_DEC: begin
                n_seen = (r_seen == 5'd31) ? r_seen : r_seen + 5'd1;
                n_acc  = acc_new;
                n_pw   = pw_new;
                if (r_last) begin
                    n_mcand  = DIV_W'(acc_new);
                    n_mplier = res_nz;
                    n_prod   = '0;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_pw     = ACC_W'(1);
                    n_seen   = '0;
                end
            end
            B_MUL: begin
                if (r_mplier[0]) n_prod = r_prod + r_mcand;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == 7'(RES_W - 1)) begin
                    n_cnt    = '0;
                    n_rem100 = '0;
                end
            end
            B_C100: begin
                // Dividend bits leave at the top while quotient bits enter at the bottom.
                n_prod   = {r_prod[DIV_W-CHUNK_W-1:0], c_q};
                n_rem100 = c_r;
                n_cnt    = r_cnt + 7'd1;
            end
            B_DIV: begin
                if (div_done) begin
                    n_bin = div_q[ACC_W-1:0];
                    n_v   = div_q[ACC_W-1:0];
                    n_bcd = '0;
                    n_cnt = '0;
                end
            end
            B_FOUT: begin
                if (out_free) begin
                    n_ov                 = 1'b1;
                    n_out.result_kind    = 1'b1;
                    n_out.field_byte_out = 8'd0;
                    n_out.run_end        = 1'b0;
                    n_out.freq_out       = fsat;
                    n_out.freq_valid     = (fsat >= i_cfg.freq_min) && (fsat <= i_cfg.freq_max);
                end
            end
            B_DD: begin
                n_bcd = {bcd_adj[4*NUM_DIGITS-2:0], r_bin[ACC_W-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt + 7'd1;
            end
            B_EMIT: begin
                if (out_free) begin
                    n_ov                 = 1'b1;
                    n_out.result_kind    = 1'b0;
                    n_out.field_byte_out = enc_byte;
                    n_out.run_end        = (r_idx == nbytes - CNT_W'(1));
                    n_out.freq_out       = '0;
                    n_out.freq_valid     = 1'b0;
                    n_idx                = r_idx + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_acc   <= '0;
            r_pw    <= ACC_W'(1);
            r_seen  <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pw    <= n_pw;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_dvsr   <= n_dvsr;
        r_rem100 <= n_rem100;
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_v      <= n_v;
        r_out    <= n_out;
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

// ===== design/cfu_checker.sv =====
// Port-level checker for the frequency field codec, bound to the top level.
`include "cat_frequency_field_codec_unit_macros.svh"

module cfu_checker import cfu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    `CFU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "stalled result dropped")
    `CFU_ASSERT(a_dec_shape, m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[7:0] == 8'd0 && !m_axis_tlast), "decode result carries byte fields")
    `CFU_ASSERT(a_enc_shape, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:8] == 56'd0, "encode result carries frequency fields")
    `CFU_ASSERT(a_freq_cap, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[61:8] <= FREQ_CAP, "decoded frequency above cap")

endmodule

bind cat_frequency_field_codec_unit cfu_checker u_cfu_checker (.*);

// ===== dv/cfu_checker.sv =====
// Checker of the frequency field codec: predicts results from accepted transfers and compares them.
module cfu_scoreboard import cfu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] ALL_ONES = '1;

    t_cfg      cfg;
    bit [63:0] dec_acc;
    bit [63:0] dec_weight;
    bit [4:0]  dec_seen;
    t_res      expected_results[$];
    int        mismatches;

    assign o_fail_count = mismatches;

    function automatic bit [63:0] mul_sat(bit [63:0] a, bit [63:0] b);
        if (a != 0 && b > ALL_ONES / a) return ALL_ONES;
        return a * b;
    endfunction

    function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
        return (a > ALL_ONES - b) ? ALL_ONES : a + b;
    endfunction

    function automatic bit [63:0] eff_res();
        return (cfg.resolution_centi == 0) ? 64'd1 : 64'(cfg.resolution_centi);
    endfunction

    function automatic int field_size();
        int n;
        if (cfg.field_format == FMT_BCD) n = (int'(cfg.field_length) + 1) / 2;
        else if (cfg.field_format == FMT_BIN || cfg.field_format == FMT_DEC)
            n = cfg.field_length;
        else n = 0;
        return (n > DEF_MAX_FIELD_BYTES) ? DEF_MAX_FIELD_BYTES : n;
    endfunction

    // Splits the scaled frequency into field bytes, least significant first, then queues
    // them in send order.
    function automatic void predict_encode(bit [FREQ_W-1:0] f);
        bit [7:0]  lsb[DEF_MAX_FIELD_BYTES];
        bit [63:0] v;
        int        n;
        t_res      r;
        n = field_size();
        v = (64'(f) * 64'd100) / eff_res();
        for (int i = 0; i < n; i++) begin
            if (cfg.field_format == FMT_BCD) begin
                lsb[i][3:0] = 4'(v % 10);
                v = v / 10;
                lsb[i][7:4] = 4'(v % 10);
                v = v / 10;
            end else if (cfg.field_format == FMT_BIN) begin
                lsb[i] = v[7:0];
                v = v >> 8;
            end else begin
                lsb[i] = ASCII_ZERO + 8'(v % 10);
                v = v / 10;
            end
        end
        for (int i = 0; i < n; i++) begin
            r = '0;
            r.field_byte_out = cfg.least_first ? lsb[i] : lsb[n-1-i];
            r.run_end = (i == n - 1);
            expected_results.push_back(r);
        end
    endfunction

    // Accumulates one field byte; the final byte scales, saturates and range checks.
    function automatic void predict_decode(bit [7:0] b, bit last);
        bit [63:0] base, val, q, rem, res, f;
        t_res      r;
        if (cfg.field_format != 2'd3 && int'(dec_seen) < field_size()) begin
            if (cfg.field_format == FMT_BCD) begin
                base = 100;
                val = 64'(b[7:4]) * 10 + 64'(b[3:0]);
            end else if (cfg.field_format == FMT_BIN) begin
                base = 256;
                val = 64'(b);
            end else begin
                base = 10;
                val = 64'(8'(b - ASCII_ZERO));
            end
            if (cfg.least_first) begin
                dec_acc = add_sat(dec_acc, mul_sat(val, dec_weight));
                dec_weight = mul_sat(dec_weight, base);
            end else begin
                dec_acc = add_sat(mul_sat(dec_acc, base), val);
            end
        end
        if (dec_seen < 31) dec_seen++;
        if (!last) return;
        res = eff_res();
        q = dec_acc / 100;
        rem = dec_acc % 100;
        if (q > 64'(FREQ_CAP) / res) begin
            f = 64'(FREQ_CAP);
        end else begin
            f = q * res + (rem * res) / 100;
            if (f > 64'(FREQ_CAP)) f = 64'(FREQ_CAP);
        end
        r = '0;
        r.result_kind = 1'b1;
        r.freq_out = f[FREQ_W-1:0];
        r.freq_valid = (f >= 64'(cfg.freq_min)) && (f <= 64'(cfg.freq_max));
        expected_results.push_back(r);
        dec_acc = 0;
        dec_weight = 1;
        dec_seen = 0;
    endfunction

    function automatic void check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            cfg.field_format <= FMT_BCD;
            cfg.least_first <= 1'b0;
            cfg.field_length <= 5'd8;
            cfg.resolution_centi <= CENTI_BASE;
            cfg.freq_min <= '0;
            cfg.freq_max <= FREQ_CAP;
            dec_acc = 0;
            dec_weight = 1;
            dec_seen = 0;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[5:3]))
                    REG_FORMAT:      cfg.field_format <= pwdata[1:0];
                    REG_LEAST_FIRST: cfg.least_first <= pwdata[0];
                    REG_LENGTH:      cfg.field_length <= pwdata[4:0];
                    REG_RES:         cfg.resolution_centi <= pwdata[RES_W-1:0];
                    REG_FMIN:        cfg.freq_min <= pwdata[FREQ_W-1:0];
                    REG_FMAX:        cfg.freq_max <= pwdata[FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_op'(s_axis_tuser) == OP_ENC) predict_encode(s_axis_tdata[53:0]);
                else predict_decode(s_axis_tdata[61:54], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time,
                             m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("result_kind", exp_r.result_kind, m_axis_tuser);
                    check_field("field_byte_out", exp_r.field_byte_out, m_axis_tdata[7:0]);
                    check_field("run_end", exp_r.run_end, m_axis_tlast);
                    check_field("freq_out", exp_r.freq_out, m_axis_tdata[61:8]);
                    check_field("freq_valid", exp_r.freq_valid, m_axis_tdata[62]);
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

// ===== dv/tb_cat_frequency_field_codec_unit.sv =====
// Stimulus and verdict for the frequency field codec; checking lives in cfu_scoreboard.
module tb_cat_frequency_field_codec_unit;
    import cfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // An encode runs through the divider and the decimal shift stage before its bytes go out, so
    // the block is given this long to finish work that leaves nothing to wait for.
    localparam int DRAIN_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int NUM_PHASES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // freq_in [53:0], field_byte_in [61:54], zeros above
    logic        s_axis_tuser = 1'b0;   // req_type
    logic        s_axis_tlast = 1'b0;   // field_end_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // field_byte_out [7:0], freq_out [61:8],
                                        // freq_valid [62], zero above
    logic        m_axis_tuser;          // result_kind
    logic        m_axis_tlast;          // run_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;

    // Local copy of the field layout, used only to shape decode sequences.
    logic [1:0] cur_format = FMT_BCD;
    logic [4:0] cur_length = 5'd8;

    // Once set, neither side of the stream idles any more.
    bit steady_tail = 1'b0;
    int sink_stall = 0;
    bit sink_calm = 1'b0;

    cat_frequency_field_codec_unit uut (.*);

    cfu_scoreboard checker_i (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending_results)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls in random bursts, with calm stretches in between.
    always @(posedge i_clk) begin
        if (steady_tail || !i_rst_n) begin
            m_axis_tready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
            if (!sink_calm && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // A register write: a setup cycle, then an access cycle that the block takes.
    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(idx) << 3;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_FORMAT) cur_format = value[1:0];
        if (idx == REG_LENGTH) cur_length = value[4:0];
    endtask

    // One input transfer. The valid is left high so a back-to-back transfer follows
    // without a dip; a gap lowers it first.
    task automatic send_xfer(t_op op, logic [53:0] freq, logic [7:0] fbyte, logic last);
        int gap;
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        s_axis_tdata <= {2'b00, fbyte, freq};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic encode(logic [53:0] freq);
        send_xfer(OP_ENC, freq, 8'($urandom), 1'($urandom));
    endtask

    task automatic decode(logic [7:0] fbyte, logic last);
        send_xfer(OP_DEC, 54'({$urandom, $urandom}), fbyte, last);
    endtask

    // Waits until every expected result has come, then lets any silent work finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int bytes_in_field();
        int n;
        if (cur_format == FMT_BCD) n = (int'(cur_length) + 1) / 2;
        else if (cur_format == FMT_BIN || cur_format == FMT_DEC) n = cur_length;
        else n = 0;
        return (n > DEF_MAX_FIELD_BYTES) ? DEF_MAX_FIELD_BYTES : n;
    endfunction

    // A byte that is a legal digit pair, binary byte or ASCII digit for the current layout.
    function automatic logic [7:0] digit_byte();
        if (cur_format == FMT_BCD)
            return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        if (cur_format == FMT_DEC) return ASCII_ZERO + 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    function automatic logic [53:0] random_freq();
        case ($urandom_range(0, 3))
            0:       return 54'($urandom_range(0, 100000));
            1:       return 54'({$urandom, $urandom});
            2:       return FREQ_CAP - 54'($urandom_range(0, 1000));
            default: return 54'({$urandom, $urandom}) % FREQ_CAP;
        endcase
    endfunction

    // Mostly whole fields of legal digits; some end early, run long, carry noise or
    // have an encode slipped in between their bytes. Returns the transfers sent.
    task automatic decode_sequence(output int sent);
        int n, len, shape;
        logic [7:0] fbyte;
        n = bytes_in_field();
        shape = $urandom_range(0, 9);
        len = (n == 0) ? $urandom_range(1, 3) : n;
        if (shape == 7) len = $urandom_range(1, len);
        if (shape == 8) len = len + $urandom_range(1, 3);
        sent = 0;
        for (int i = 0; i < len; i++) begin
            fbyte = (shape == 9) ? 8'($urandom) : digit_byte();
            if (i > 0 && $urandom_range(0, 19) == 0) begin
                encode(random_freq());
                sent++;
            end
            decode(fbyte, i == len - 1);
            sent++;
        end
    endtask

    task automatic configure(int phase);
        case (phase)
            0: begin
                write_reg(REG_FORMAT, FMT_BCD);
                write_reg(REG_LEAST_FIRST, 0);
                write_reg(REG_LENGTH, 8);
                write_reg(REG_RES, 100);
                write_reg(REG_FMIN, 0);
                write_reg(REG_FMAX, FREQ_CAP);
            end
            1: begin
                write_reg(REG_FORMAT, FMT_BIN);
                write_reg(REG_LEAST_FIRST, 1);
                write_reg(REG_LENGTH, 16);
                write_reg(REG_RES, 1);
                write_reg(REG_FMIN, 1000);
                write_reg(REG_FMAX, 64'd5000000000);
            end
            2: begin
                // Longest length code and every resolution bit set; the field caps at 16.
                write_reg(REG_FORMAT, FMT_DEC);
                write_reg(REG_LEAST_FIRST, 0);
                write_reg(REG_LENGTH, 31);
                write_reg(REG_RES, 17'h1FFFF);
                write_reg(REG_FMIN, 0);
                write_reg(REG_FMAX, 54'h3FFFFFFFFFFFFF);
            end
            3: begin
                // Zero resolution counts as one unit.
                write_reg(REG_FORMAT, FMT_BCD);
                write_reg(REG_LEAST_FIRST, 1);
                write_reg(REG_LENGTH, 1);
                write_reg(REG_RES, 0);
                write_reg(REG_FMIN, 54'h2AAAAAAAAAAAAA);
                write_reg(REG_FMAX, 54'h15555555555555);
            end
            4: begin
                // The unused format code: encodes stay silent, decodes yield zero.
                write_reg(REG_FORMAT, 3);
                write_reg(REG_LEAST_FIRST, 0);
                write_reg(REG_LENGTH, 5);
                write_reg(REG_RES, 250);
            end
            5: begin
                // Zero length behaves like the unused format.
                write_reg(REG_FORMAT, FMT_BIN);
                write_reg(REG_LENGTH, 0);
                write_reg(REG_RES, 100000);
                write_reg(REG_FMIN, 0);
            end
            6: begin
                // Minimum above maximum, so nothing decodes as in range.
                write_reg(REG_FORMAT, FMT_DEC);
                write_reg(REG_LEAST_FIRST, 1);
                write_reg(REG_LENGTH, 7);
                write_reg(REG_RES, 1000);
                write_reg(REG_FMIN, 64'd900000000);
                write_reg(REG_FMAX, 64'd100);
            end
            default: begin
                write_reg(REG_FORMAT, FMT_BCD);
                write_reg(REG_LEAST_FIRST, 0);
                write_reg(REG_LENGTH, 16);
                write_reg(REG_RES, 100);
                write_reg(REG_FMIN, 0);
                write_reg(REG_FMAX, FREQ_CAP);
            end
        endcase
    endtask

    initial begin
        int sent, done;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            configure(phase);
            if (phase == NUM_PHASES - 1) steady_tail = 1'b1;
            if (phase == 0) begin
                // Directed part: frequency extremes, full BCD digits, nibbles above nine,
                // an early end, surplus bytes, and an encode between decode bytes.
                encode('0);
                encode(FREQ_CAP);
                encode('1);
                encode(54'd14250000);
                decode(8'h12, 1'b0);
                decode(8'h34, 1'b0);
                decode(8'h56, 1'b0);
                decode(8'h78, 1'b1);
                decode(8'hFA, 1'b0);
                decode(8'hFF, 1'b1);
                for (int i = 0; i < 6; i++) decode(8'h99, i == 5);
                decode(8'h00, 1'b0);
                encode(54'd7074000);
                decode(8'h07, 1'b0);
                decode(8'h40, 1'b1);
                decode(8'h00, 1'b1);
            end
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 4) begin
                    encode(random_freq());
                    done++;
                end else begin
                    decode_sequence(sent);
                    done += sent;
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every encode filling sixteen bytes, each behind
    // the longest stall.
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
